/* hw/rtl/pcbp_pkg.sv */
// ============================================================================
// pcbp_pkg
// Shared widths, opcodes, state encoding and result type for the prefix code
// bit packer.
// ============================================================================
package pcbp_pkg;

    localparam int MAX_CODE_LEN_DEF = 16;   // default cap on stored code length
    localparam int CODE_FIELD_W     = 16;   // code_word field width
    localparam int LEN_FIELD_W      = 5;    // code_length field width
    localparam int SYM_W            = 8;
    localparam int BYTE_W           = 8;
    localparam int OP_W             = 2;
    localparam int NUM_SYMBOLS      = 1 << SYM_W;
    localparam int ACC_W            = 3 * BYTE_W;  // partial byte plus longest code
    localparam int TOT_W            = 5;           // pending bits plus length, up to 23

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
        logic              missing_symbol;
    } t_result;

endpackage

/* hw/rtl/pcbp_in_if.sv */
// ============================================================================
// pcbp_in_if
// Request channel: opcode, symbol and code entry fields with valid/ready.
// ============================================================================
interface pcbp_in_if
    import pcbp_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         opcode;
    logic [SYM_W-1:0]        symbol;
    logic [CODE_FIELD_W-1:0] code_word;
    logic [LEN_FIELD_W-1:0]  code_length;

    modport source (output valid, opcode, symbol, code_word, code_length, input ready);
    modport sink   (input valid, opcode, symbol, code_word, code_length, output ready);
endinterface

/* hw/rtl/pcbp_out_if.sv */
// ============================================================================
// pcbp_out_if
// Result channel: packed byte, last mark and missing-symbol flag.
// ============================================================================
interface pcbp_out_if
    import pcbp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic              missing_symbol;

    modport source (output valid, out_byte, last, missing_symbol, input ready);
    modport sink   (input valid, out_byte, last, missing_symbol, output ready);
endinterface

/* hw/rtl/prefix_code_bit_packer.sv */
// ============================================================================
// prefix_code_bit_packer
// Packs variable-length prefix codes, low bit first, into bytes.
// ============================================================================
// Usage:
//   i_req carries requests: load (store code word and length for a symbol),
//   encode (append the symbol's code to the bit stream) and flush (emit the
//   pending partial byte, zero padded). o_res carries result bytes; last
//   marks the final result of a request, missing_symbol marks an encode of a
//   symbol with no table entry.
//   The code table sits in one 256-entry RAM with registered read data;
//   valid marks for the entries live in flip-flops.
//   Load and flush complete in ST_IDLE when accepted. An encode is accepted
//   in ST_IDLE, which issues the table read; in ST_LOOKUP the read returns
//   and the first byte is formed; a code that completes two bytes goes on
//   to ST_EMIT to emit the second byte; both wait for a free result slot.
//   A load followed at once by an encode of the same symbol reads the new
//   entry: the write lands before the read is issued.
//   Reset clears the valid marks, the partial byte and the bit count; no
//   clearing pass is needed. A stalled receiver holds the result register,
//   and no new request is taken until the result slot frees.
// ============================================================================
module prefix_code_bit_packer
    import pcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pcbp_in_if.sink    i_req,
    pcbp_out_if.source o_res
);

    // Stored codes are capped at the smaller of the parameter and the field.
    localparam int CAP    = (MAX_CODE_LEN < CODE_FIELD_W) ? MAX_CODE_LEN : CODE_FIELD_W;
    localparam int LEN_SW = $clog2(CAP + 1);
    localparam int ENT_W  = CAP + LEN_SW;

    t_state                r_state, n_state;
    logic [BYTE_W-1:0]     r_partial, n_partial;
    logic [2:0]            r_bitpos, n_bitpos;
    logic [NUM_SYMBOLS-1:0] r_valid, n_valid;
    logic                  r_hit, n_hit;
    logic [2*BYTE_W-1:0]   r_hold, n_hold;
    logic [TOT_W-1:0]      r_total, n_total;
    logic                  r_o_valid, n_o_valid;
    t_result               r_o, n_o;

    logic                  in_accept;
    logic                  out_free;
    logic                  ram_we, ram_re;
    logic [LEN_FIELD_W-1:0] len_clamped;
    logic [CAP-1:0]        code_masked;
    logic [ENT_W-1:0]      ram_rdata;
    logic [CAP-1:0]        rd_code;
    logic [LEN_SW-1:0]     rd_len;
    logic [ACC_W-1:0]      c_acc;
    logic [TOT_W-1:0]      c_total;

    // Result slot frees when empty or being taken this cycle.
    assign out_free    = !r_o_valid || o_res.ready;
    assign i_req.ready = (r_state == ST_IDLE) && out_free;
    assign in_accept   = i_req.valid && i_req.ready;

    // Load path: clamp the length and drop code bits above it.
    always_comb begin
        len_clamped = (i_req.code_length > LEN_FIELD_W'(CAP)) ?
                      LEN_FIELD_W'(CAP) : i_req.code_length;
        for (int b = 0; b < CAP; b++) begin
            code_masked[b] = i_req.code_word[b] && (LEN_FIELD_W'(b) < len_clamped);
        end
    end

    pcbp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_SYMBOLS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_req.symbol),
        .i_wdata ({code_masked, LEN_SW'(len_clamped)}),
        .i_re    (ram_re),
        .i_raddr (i_req.symbol),
        .o_rdata (ram_rdata)
    );

    assign rd_code = ram_rdata[ENT_W-1:LEN_SW];
    assign rd_len  = ram_rdata[LEN_SW-1:0];

    // Append the looked-up code above the pending bits.
    always_comb begin
        c_acc   = ACC_W'(r_partial) | (ACC_W'(rd_code) << r_bitpos);
        c_total = TOT_W'(r_bitpos) + TOT_W'(rd_len);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept && (i_req.opcode == OP_ENCODE)) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (out_free) begin
                    n_state = (r_hit && (c_total >= TOT_W'(2 * BYTE_W))) ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_partial = r_partial;
        n_bitpos  = r_bitpos;
        n_valid   = r_valid;
        n_hit     = r_hit;
        n_hold    = r_hold;
        n_total   = r_total;
        n_o_valid = r_o_valid && !o_res.ready;
        n_o       = r_o;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    case (i_req.opcode)
                        OP_LOAD: begin
                            ram_we                 = 1'b1;
                            n_valid[i_req.symbol]  = 1'b1;
                        end
                        OP_ENCODE: begin
                            ram_re = 1'b1;
                            n_hit  = r_valid[i_req.symbol];
                        end
                        OP_FLUSH: begin
                            // Emit the pending bits; nothing pending means no result.
                            if (r_bitpos != 3'd0) begin
                                n_o_valid          = 1'b1;
                                n_o.out_byte       = r_partial;
                                n_o.last           = 1'b1;
                                n_o.missing_symbol = 1'b0;
                                n_partial          = '0;
                                n_bitpos           = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOOKUP: begin
                if (out_free) begin
                    if (!r_hit) begin
                        n_o_valid          = 1'b1;
                        n_o.out_byte       = '0;
                        n_o.last           = 1'b1;
                        n_o.missing_symbol = 1'b1;
                    end else if (c_total < TOT_W'(BYTE_W)) begin
                        // Not a full byte yet: hold the bits.
                        n_partial = c_acc[BYTE_W-1:0];
                        n_bitpos  = c_total[2:0];
                    end else begin
                        n_o_valid          = 1'b1;
                        n_o.out_byte       = c_acc[BYTE_W-1:0];
                        n_o.last           = (c_total < TOT_W'(2 * BYTE_W));
                        n_o.missing_symbol = 1'b0;
                        if (c_total >= TOT_W'(2 * BYTE_W)) begin
                            n_hold  = c_acc[ACC_W-1:BYTE_W];
                            n_total = c_total;
                        end else begin
                            n_partial = c_acc[2*BYTE_W-1:BYTE_W];
                            n_bitpos  = c_total[2:0];
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_o_valid          = 1'b1;
                    n_o.out_byte       = r_hold[BYTE_W-1:0];
                    n_o.last           = 1'b1;
                    n_o.missing_symbol = 1'b0;
                    n_partial          = r_hold[2*BYTE_W-1:BYTE_W];
                    n_bitpos           = r_total[2:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_partial <= '0;
            r_bitpos  <= '0;
            r_valid   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_partial <= n_partial;
            r_bitpos  <= n_bitpos;
            r_valid   <= n_valid;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers hold without reset.
    always_ff @(posedge i_clk) begin
        r_hit   <= n_hit;
        r_hold  <= n_hold;
        r_total <= n_total;
        r_o     <= n_o;
    end

    assign o_res.valid          = r_o_valid;
    assign o_res.out_byte       = r_o.out_byte;
    assign o_res.last           = r_o.last;
    assign o_res.missing_symbol = r_o.missing_symbol;

endmodule

/* hw/rtl/pcbp_ram.sv */
// ============================================================================
// pcbp_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module pcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/pcbp_checker.sv */
// ============================================================================
// pcbp_checker
// Port-level checks on the prefix code bit packer, bound to the top level.
// ============================================================================
module pcbp_checker
    import pcbp_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic [OP_W-1:0]   i_in_opcode,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [BYTE_W-1:0] i_out_byte,
    input logic              i_out_last,
    input logic              i_out_missing
);

    // Reset empties the result slot.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A missing-symbol result is a single zero byte closing its request.
    a_missing_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_missing) |-> (i_out_last && (i_out_byte == '0)))
        else $error("missing-symbol result malformed");

    // No request is taken while a result is stalled.
    a_no_take_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("request taken while result stalled");

    // A load produces no result.
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_opcode == OP_LOAD)) |=> !i_out_valid)
        else $error("load produced a result");

endmodule

bind prefix_code_bit_packer pcbp_checker u_pcbp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_in_opcode   (i_req.opcode),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_out_byte    (o_res.out_byte),
    .i_out_last    (o_res.last),
    .i_out_missing (o_res.missing_symbol)
);
